// ----- rtl/cbeq_pkg.sv -----
// Shared types, codes and saturation helpers for the crossfaded biquad equalizer.
package cbeq_pkg;

	localparam int X_W       = 32;
	localparam int PROD_W    = 44;
	localparam int Z_W       = 48;
	localparam int SUM_W     = 50;
	localparam int NUM_COEFS = 5;
	localparam int TOK_CH_W  = 4;

	localparam logic [2:0] OP_SAMPLE = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_COMMIT = 3'd2;
	localparam logic [2:0] OP_DROP   = 3'd3;
	localparam logic [2:0] OP_RESET  = 3'd4;

	localparam logic [2:0] SEL_B0 = 3'd0;
	localparam logic [2:0] SEL_B1 = 3'd1;
	localparam logic [2:0] SEL_B2 = 3'd2;
	localparam logic [2:0] SEL_A1 = 3'd3;
	localparam logic [2:0] SEL_A2 = 3'd4;

	localparam logic [1:0] REG_CHANNEL_COUNT   = 2'd0;
	localparam logic [1:0] REG_FADE_FRAMES     = 2'd1;
	localparam logic [1:0] REG_FADE_RECIPROCAL = 2'd2;

	typedef struct packed {
		logic       stage_we;
		logic [2:0] band;
		logic [2:0] sel;
		logic       copy_en;
		logic       copy_bank;
		logic [1:0] clear;
	} cbeq_cmd_t;

	typedef struct packed {
		logic                valid;
		logic                bank;
		logic [TOK_CH_W-1:0] ch;
	} cbeq_tok_t;

	function automatic logic signed [Z_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = (SUM_W'(1) <<< (Z_W - 1)) - SUM_W'(1);
		lo = -hi - SUM_W'(1);
		if (v > hi)
			return hi[Z_W-1:0];
		else if (v < lo)
			return lo[Z_W-1:0];
		return v[Z_W-1:0];
	endfunction

	function automatic logic signed [X_W-1:0] sat32(input logic signed [Z_W-9:0] v);
		logic signed [Z_W-9:0] hi;
		logic signed [Z_W-9:0] lo;
		hi = ((Z_W-8)'(1) <<< (X_W - 1)) - (Z_W-8)'(1);
		lo = -hi - (Z_W-8)'(1);
		if (v > hi)
			return hi[X_W-1:0];
		else if (v < lo)
			return lo[X_W-1:0];
		return v[X_W-1:0];
	endfunction

endpackage

// ----- rtl/cbeq_cell.sv -----
// One biquad section: coefficient banks, per-channel state and a pipelined datapath (stages s1 to s3).
module cbeq_cell import cbeq_pkg::*; #(
	parameter int BAND         = 0,
	parameter int MAX_CHANNELS = 8,
	parameter int COEF_BITS    = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cbeq_cmd_t                   cmd,
	input  logic signed [COEF_BITS-1:0] coef_value,
	input  cbeq_tok_t                   in_tok,
	input  logic signed [X_W-1:0]       in_x,
	output cbeq_tok_t                   out_tok,
	output logic signed [X_W-1:0]       out_x
);

	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int DEPTH  = 2 ** (CH_W + 1);
	localparam int FULL_W = COEF_BITS + X_W;
	localparam int SHIFT  = COEF_BITS - 12;
	localparam logic signed [COEF_BITS-1:0] ONE = COEF_BITS'(1) <<< (COEF_BITS - 4);

	function automatic logic signed [PROD_W-1:0] mul(input logic signed [COEF_BITS-1:0] c,
		input logic signed [X_W-1:0] x);
		logic signed [FULL_W-1:0] f;
		f = FULL_W'(c) * FULL_W'(x);
		return PROD_W'(f >>> SHIFT);
	endfunction

	function automatic logic [CH_W:0] addr(input cbeq_tok_t t);
		return {t.bank, t.ch[CH_W-1:0]};
	endfunction

	logic signed [COEF_BITS-1:0] stage_q [NUM_COEFS];
	logic signed [COEF_BITS-1:0] bank_q  [2][NUM_COEFS];
	logic signed [Z_W-1:0]       z1_q    [DEPTH];
	logic signed [Z_W-1:0]       z2_q    [DEPTH];
	logic [DEPTH-1:0]            z1_v_q;
	logic [DEPTH-1:0]            z2_v_q;

	cbeq_tok_t               tok_s1, tok_s2, tok_s3;
	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1, p1_s2, p2_s2, p1_s3, p2_s3, q3_s3, q4_s3;
	logic signed [X_W-1:0]    y_s2;

	logic signed [Z_W-1:0]   z1_rd, z2_rd, y48, z1_new, z2_new;
	logic signed [X_W-1:0]   y_d;
	logic [CH_W:0]           a2, a3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_COEFS; k++) begin
				stage_q[k]   <= (k == 0) ? ONE : '0;
				bank_q[0][k] <= (k == 0) ? ONE : '0;
				bank_q[1][k] <= (k == 0) ? ONE : '0;
			end
		end else begin
			if (cmd.stage_we && 5'(cmd.band) == 5'(BAND))
				stage_q[cmd.sel] <= coef_value;
			if (cmd.copy_en)
				bank_q[cmd.copy_bank] <= stage_q;
		end
	end

	always_comb begin
		a2     = addr(tok_s1);
		a3     = addr(tok_s3);
		z1_rd  = z1_v_q[a2] ? z1_q[a2] : '0;
		z2_rd  = z2_v_q[a3] ? z2_q[a3] : '0;
		y48    = sat48(SUM_W'(p0_s1) + SUM_W'(z1_rd));
		y_d    = sat32((Z_W-8)'(y48 >>> 8));
		z1_new = sat48(SUM_W'(p1_s3) - SUM_W'(q3_s3) + SUM_W'(z2_rd));
		z2_new = sat48(SUM_W'(p2_s3) - SUM_W'(q4_s3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
			z1_v_q <= '0;
			z2_v_q <= '0;
		end else begin
			tok_s1 <= in_tok;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
			for (int i = 0; i < DEPTH; i++) begin
				if (cmd.clear[i >= DEPTH / 2]) begin
					z1_v_q[i] <= 1'b0;
					z2_v_q[i] <= 1'b0;
				end
			end
			if (tok_s3.valid) begin
				z1_v_q[a3] <= 1'b1;
				z2_v_q[a3] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		p0_s1 <= mul(bank_q[in_tok.bank][SEL_B0], in_x);
		p1_s1 <= mul(bank_q[in_tok.bank][SEL_B1], in_x);
		p2_s1 <= mul(bank_q[in_tok.bank][SEL_B2], in_x);
		y_s2  <= y_d;
		p1_s2 <= p1_s1;
		p2_s2 <= p2_s1;
		q3_s3 <= mul(bank_q[tok_s2.bank][SEL_A1], y_s2);
		q4_s3 <= mul(bank_q[tok_s2.bank][SEL_A2], y_s2);
		p1_s3 <= p1_s2;
		p2_s3 <= p2_s2;
		if (tok_s3.valid) begin
			z1_q[a3] <= z1_new;
			z2_q[a3] <= z2_new;
		end
	end

	assign out_tok = tok_s2;
	assign out_x   = y_s2;

endmodule

// ----- rtl/crossfaded_biquad_equalizer.sv -----
// Top level: opcode decode, bank and fade control, crossfade mixer and output register.
//
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the opcode.
// Every input word yields exactly one output word on m_tvalid/m_tready/m_tdata/m_tuser.
// One word is in work at a time: s_tready is high only when the block is idle.
// A sample word runs through a row of NUM_BANDS section cells, via registers s1 and s2
// of each cell, once for the active bank and, during a crossfade, once more in the
// cycle after it for the new bank; the mixer states F1, F2 and F3 and the output load
// follow. Other opcodes go straight from acceptance to the output load.
// The output register holds a finished word while the receiver stalls, and the next
// input word may be accepted meanwhile; a word waits in the block until the register
// frees. Reset returns identity coefficients in all banks, zero filter state, bank 0
// active, no fade and register defaults: two channels, 1440 frames, reciprocal 11651.
// The user must write registers through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this.
module crossfaded_biquad_equalizer import cbeq_pkg::*; #(
	parameter int NUM_BANDS    = 8,
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 24,
	parameter int COEF_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// channel, sample_in, band_index, coef_select, coef_value
	input  logic [((9 + SAMPLE_BITS + COEF_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// opcode
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// sample_out
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// channel_error, fading, pending
	output logic [2:0]  m_tuser
);

	localparam int OFF_SMP  = 3;
	localparam int OFF_BAND = OFF_SMP + SAMPLE_BITS;
	localparam int OFF_SEL  = OFF_BAND + 3;
	localparam int OFF_COEF = OFF_SEL + 3;
	localparam int OUT_DW   = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int RES_W    = X_W + 4;
	localparam logic [4:0]  MAXC = 5'(MAX_CHANNELS);
	localparam logic [4:0]  NBANDS = 5'(NUM_BANDS);
	localparam logic [41:0] P_ONE = 42'(1) << 24;
	localparam logic signed [RES_W-1:0] HI = (RES_W'(1) <<< (SAMPLE_BITS - 1)) - RES_W'(1);
	localparam logic signed [RES_W-1:0] LO = -HI - RES_W'(1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_F1   = 3'd2;
	localparam logic [2:0] ST_F2   = 3'd3;
	localparam logic [2:0] ST_F3   = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]  state_q;
	logic        active_q, fade_q, wait_q, second_q;
	logic [15:0] fc_q;
	logic [3:0]  chcnt_q;
	logic [15:0] frames_q;
	logic [24:0] recip_q;
	logic [2:0]  ch_q;
	logic signed [X_W-1:0] x_q, cur_q, nxt_q, cur_s1, cur_s2;
	cbeq_tok_t   tok_q;
	logic [41:0] pprod_s1;
	logic signed [X_W:0] diff_s1;
	logic signed [X_W+26:0] mix_s2;
	logic [SAMPLE_BITS-1:0] res_q;
	logic        err_q;

	logic [2:0]  op;
	logic [2:0]  ch_in, band_in, sel_in;
	logic signed [SAMPLE_BITS-1:0] smp_in;
	logic signed [COEF_BITS-1:0]   coef_in;
	logic [4:0]  cnt;
	logic        accept, ch_ok, last_ch, fade_end;
	logic [15:0] fc_next;
	logic [24:0] pcl;
	logic signed [RES_W-1:0] mixed;
	logic [SAMPLE_BITS-1:0]  res_sat;
	cbeq_cmd_t   cmd;

	cbeq_tok_t             chain_tok [NUM_BANDS+1];
	logic signed [X_W-1:0] chain_x   [NUM_BANDS+1];

	assign op      = s_tuser;
	assign ch_in   = s_tdata[2:0];
	assign smp_in  = $signed(s_tdata[OFF_BAND-1:OFF_SMP]);
	assign band_in = s_tdata[OFF_SEL-1:OFF_BAND];
	assign sel_in  = s_tdata[OFF_COEF-1:OFF_SEL];
	assign coef_in = $signed(s_tdata[OFF_COEF+COEF_BITS-1:OFF_COEF]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cnt      = (5'(chcnt_q) > MAXC) ? MAXC : 5'(chcnt_q);
	assign ch_ok    = 5'(ch_in) < cnt;
	assign last_ch  = (5'(ch_q) + 5'd1) == cnt;
	assign fc_next  = fc_q + 16'd1;
	assign fade_end = fade_q && last_ch && (fc_next >= frames_q);
	assign pcl      = (pprod_s1 > P_ONE) ? P_ONE[24:0] : pprod_s1[24:0];

	always_comb begin
		mixed = fade_q ? RES_W'(cur_s2) + RES_W'(mix_s2 >>> 24) : RES_W'(cur_s2);
		if (mixed > HI)
			res_sat = HI[SAMPLE_BITS-1:0];
		else if (mixed < LO)
			res_sat = LO[SAMPLE_BITS-1:0];
		else
			res_sat = mixed[SAMPLE_BITS-1:0];
	end

	always_comb begin
		cmd = '0;
		cmd.band = band_in;
		cmd.sel  = sel_in;
		if (accept) begin
			unique case (op)
				OP_WRITE: cmd.stage_we = (5'(band_in) < NBANDS) && (sel_in <= SEL_A2);
				OP_COMMIT: begin
					if (!fade_q) begin
						cmd.copy_en   = 1'b1;
						cmd.copy_bank = !active_q;
						cmd.clear[!active_q] = 1'b1;
					end
				end
				OP_RESET: begin
					cmd.copy_en   = wait_q;
					cmd.copy_bank = active_q;
					cmd.clear     = 2'b11;
				end
				default: ;
			endcase
		end else if (state_q == ST_F3 && fade_end && wait_q) begin
			cmd.copy_en   = 1'b1;
			cmd.copy_bank = active_q;
			cmd.clear[active_q] = 1'b1;
		end
	end

	assign chain_tok[0] = tok_q;
	assign chain_x[0]   = x_q;

	for (genvar b = 0; b < NUM_BANDS; b++) begin : g_cell
		cbeq_cell #(
			.BAND         (b),
			.MAX_CHANNELS (MAX_CHANNELS),
			.COEF_BITS    (COEF_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.coef_value (coef_in),
			.in_tok     (chain_tok[b]),
			.in_x       (chain_x[b]),
			.out_tok    (chain_tok[b+1]),
			.out_x      (chain_x[b+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chcnt_q  <= 4'd2;
			frames_q <= 16'd1440;
			recip_q  <= 25'd11651;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT:   chcnt_q  <= cfg_data[3:0];
				REG_FADE_FRAMES:     frames_q <= cfg_data[15:0];
				REG_FADE_RECIPROCAL: recip_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b0;
			fade_q   <= 1'b0;
			wait_q   <= 1'b0;
			fc_q     <= '0;
			second_q <= 1'b0;
			tok_q    <= '0;
			m_tvalid <= 1'b0;
			err_q    <= 1'b0;
			res_q    <= '0;
		end else begin
			if (state_q == ST_DONE && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q   <= '0;
						err_q   <= 1'b0;
						state_q <= ST_DONE;
						unique case (op)
							OP_SAMPLE: begin
								if (ch_ok) begin
									tok_q    <= '{valid: 1'b1, bank: active_q,
										ch: TOK_CH_W'(ch_in)};
									second_q <= fade_q;
									state_q  <= ST_RUN;
								end else begin
									err_q <= 1'b1;
								end
							end
							OP_COMMIT: begin
								if (fade_q) begin
									wait_q <= 1'b1;
								end else begin
									fade_q <= 1'b1;
									fc_q   <= '0;
								end
							end
							OP_DROP: wait_q <= 1'b0;
							OP_RESET: begin
								if (!wait_q && fade_q)
									active_q <= !active_q;
								fade_q <= 1'b0;
								wait_q <= 1'b0;
								fc_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					tok_q.valid <= second_q;
					tok_q.bank  <= !active_q;
					second_q    <= 1'b0;
					if (chain_tok[NUM_BANDS].valid &&
						(chain_tok[NUM_BANDS].bank != active_q || !fade_q))
						state_q <= ST_F1;
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: begin
					res_q   <= res_sat;
					state_q <= ST_DONE;
					if (fade_q && last_ch) begin
						if (fade_end) begin
							active_q <= !active_q;
							fc_q     <= '0;
							fade_q   <= wait_q;
							wait_q   <= 1'b0;
						end else begin
							fc_q <= fc_next;
						end
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= X_W'(smp_in);
			ch_q <= ch_in;
		end
		if (chain_tok[NUM_BANDS].valid) begin
			if (chain_tok[NUM_BANDS].bank == active_q)
				cur_q <= chain_x[NUM_BANDS];
			else
				nxt_q <= chain_x[NUM_BANDS];
		end
		pprod_s1 <= 42'(17'(fc_q) + 17'd1) * 42'(recip_q);
		diff_s1  <= (X_W+1)'(nxt_q) - (X_W+1)'(cur_q);
		cur_s1   <= cur_q;
		mix_s2   <= (X_W+27)'(diff_s1) * (X_W+27)'($signed({1'b0, pcl}));
		cur_s2   <= cur_s1;
		if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
			m_tdata <= OUT_DW'(res_q);
			m_tuser <= {wait_q, fade_q, err_q};
		end
	end

	a_wait_needs_fade: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q |-> fade_q) else $error("commit pending without a fade");

	a_counter_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!fade_q |-> fc_q == '0) else $error("frame counter moved outside a fade");

	a_chain_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		chain_tok[NUM_BANDS].valid |-> state_q == ST_RUN)
		else $error("section output arrived outside the run state");

endmodule
